[design/xes_pkg.sv]
// Package for the XML encoding sniffer: candidate bits, verdict codes and state type.
package xes_pkg;

    localparam int CAND_W = 11;

    // Candidate bit positions
    localparam int CAND_U8SIG  = 0;
    localparam int CAND_16ASLE = 1;
    localparam int CAND_16ASBE = 2;
    localparam int CAND_16LE   = 3;
    localparam int CAND_16BE   = 4;
    localparam int CAND_32ASLE = 5;
    localparam int CAND_32ASBE = 6;
    localparam int CAND_32LE   = 7;
    localparam int CAND_32BE   = 8;
    localparam int CAND_CP037  = 9;
    localparam int CAND_DECL   = 10;

    localparam logic [CAND_W-1:0] CAND_ALL = {CAND_W{1'b1}};

    // Byte positions that still filter; the count saturates here
    localparam logic [2:0] COUNT_MAX = 3'd6;

    // Verdict codes
    localparam logic [3:0] VERDICT_UNDECIDED = 4'd0;
    localparam logic [3:0] VERDICT_UTF8      = 4'd1;
    localparam logic [3:0] VERDICT_UTF8SIG   = 4'd2;
    localparam logic [3:0] VERDICT_UTF16BOM  = 4'd3;
    localparam logic [3:0] VERDICT_UTF16LE   = 4'd4;
    localparam logic [3:0] VERDICT_UTF16BE   = 4'd5;
    localparam logic [3:0] VERDICT_UTF32BOM  = 4'd6;
    localparam logic [3:0] VERDICT_UTF32LE   = 4'd7;
    localparam logic [3:0] VERDICT_UTF32BE   = 4'd8;
    localparam logic [3:0] VERDICT_CP037     = 4'd9;
    localparam logic [3:0] VERDICT_DECL      = 4'd10;

    // Detection state carried between words
    typedef struct packed {
        logic [CAND_W-1:0] mask;
        logic [2:0]        count;
        logic              third_zero;
    } sniff_state_t;

endpackage

[design/xes_in_if.sv]
// Input channel: one document byte per word with restart and end flags.
interface xes_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       first_of_document;
    logic       end_of_document;

    modport source (output valid, output byte_value, output first_of_document,
                    output end_of_document, input ready);
    modport sink   (input valid, input byte_value, input first_of_document,
                    input end_of_document, output ready);
endinterface

[design/xes_out_if.sv]
// Output channel: verdict and remaining candidate mask per word.
interface xes_out_if;
    logic                       valid;
    logic                       ready;
    logic [3:0]                 verdict;
    logic [xes_pkg::CAND_W-1:0] candidates_left;

    modport source (output valid, output verdict, output candidates_left, input ready);
    modport sink   (input valid, input verdict, input candidates_left, output ready);
endinterface

[design/xes_sniff_core.sv]
// Candidate filter and verdict logic for one byte against the current state.
module xes_sniff_core (
    input  xes_pkg::sniff_state_t       cur,
    input  logic [7:0]                  byte_value,
    input  logic                        first_of_document,
    input  logic                        end_of_document,
    output xes_pkg::sniff_state_t       nxt,
    output logic [3:0]                  verdict,
    output logic [xes_pkg::CAND_W-1:0]  candidates_left
);

    logic [xes_pkg::CAND_W-1:0] base_mask;
    logic [xes_pkg::CAND_W-1:0] m;
    logic [2:0]                 pos;
    logic [2:0]                 count_new;
    logic                       base_tz;
    logic                       tz_new;
    logic                       single;
    logic [3:0]                 one_v;
    logic [3:0]                 v;

    // Restart puts the state back to its reset value
    always_comb
    begin
        base_mask = first_of_document ? xes_pkg::CAND_ALL : cur.mask;
        pos       = first_of_document ? 3'd0 : cur.count;
        base_tz   = first_of_document ? 1'b0 : cur.third_zero;
    end

    // Clear candidates whose expected byte at this position differs
    always_comb
    begin
        m = base_mask;
        case (pos)
            3'd0:
            begin
                if (byte_value != 8'hEF) m[xes_pkg::CAND_U8SIG] = 1'b0;
                if (byte_value != 8'hFF)
                begin
                    m[xes_pkg::CAND_32ASLE] = 1'b0;
                    m[xes_pkg::CAND_16ASLE] = 1'b0;
                end
                if (byte_value != 8'hFE) m[xes_pkg::CAND_16ASBE] = 1'b0;
                if (byte_value != 8'h3C)
                begin
                    m[xes_pkg::CAND_32LE] = 1'b0;
                    m[xes_pkg::CAND_16LE] = 1'b0;
                    m[xes_pkg::CAND_DECL] = 1'b0;
                end
                if (byte_value != 8'h00)
                begin
                    m[xes_pkg::CAND_32ASBE] = 1'b0;
                    m[xes_pkg::CAND_32BE]   = 1'b0;
                    m[xes_pkg::CAND_16BE]   = 1'b0;
                end
                if (byte_value != 8'h4C) m[xes_pkg::CAND_CP037] = 1'b0;
            end
            3'd1:
            begin
                if (byte_value != 8'hBB) m[xes_pkg::CAND_U8SIG] = 1'b0;
                if (byte_value != 8'hFE)
                begin
                    m[xes_pkg::CAND_16ASLE] = 1'b0;
                    m[xes_pkg::CAND_32ASLE] = 1'b0;
                end
                if (byte_value != 8'hFF) m[xes_pkg::CAND_16ASBE] = 1'b0;
                if (byte_value != 8'h00)
                begin
                    m[xes_pkg::CAND_16LE]   = 1'b0;
                    m[xes_pkg::CAND_32ASBE] = 1'b0;
                    m[xes_pkg::CAND_32LE]   = 1'b0;
                    m[xes_pkg::CAND_32BE]   = 1'b0;
                end
                if (byte_value != 8'h3C) m[xes_pkg::CAND_16BE]  = 1'b0;
                if (byte_value != 8'h6F) m[xes_pkg::CAND_CP037] = 1'b0;
                if (byte_value != 8'h3F) m[xes_pkg::CAND_DECL]  = 1'b0;
            end
            3'd2:
            begin
                if (byte_value != 8'hBF) m[xes_pkg::CAND_U8SIG] = 1'b0;
                if (byte_value != 8'h3F) m[xes_pkg::CAND_16LE]  = 1'b0;
                if (byte_value != 8'h00)
                begin
                    m[xes_pkg::CAND_32ASLE] = 1'b0;
                    m[xes_pkg::CAND_32LE]   = 1'b0;
                    m[xes_pkg::CAND_32BE]   = 1'b0;
                end
                if (byte_value != 8'hFE) m[xes_pkg::CAND_32ASBE] = 1'b0;
                if (byte_value != 8'hA7) m[xes_pkg::CAND_CP037]  = 1'b0;
                if (byte_value != 8'h78) m[xes_pkg::CAND_DECL]   = 1'b0;
            end
            3'd3:
            begin
                // FF FE 00 00 is the UTF-32 mark, not UTF-16
                if (byte_value == 8'h00 && base_tz) m[xes_pkg::CAND_16ASLE] = 1'b0;
                if (byte_value != 8'h00)
                begin
                    m[xes_pkg::CAND_16LE]   = 1'b0;
                    m[xes_pkg::CAND_32ASLE] = 1'b0;
                    m[xes_pkg::CAND_32LE]   = 1'b0;
                end
                if (byte_value != 8'hFF) m[xes_pkg::CAND_32ASBE] = 1'b0;
                if (byte_value != 8'h3C) m[xes_pkg::CAND_32BE]   = 1'b0;
                if (byte_value != 8'h94) m[xes_pkg::CAND_CP037]  = 1'b0;
                if (byte_value != 8'h6D) m[xes_pkg::CAND_DECL]   = 1'b0;
            end
            3'd4:
            begin
                if (byte_value != 8'h6C) m[xes_pkg::CAND_DECL] = 1'b0;
            end
            3'd5:
            begin
                // whitespace after "<?xml"
                if (!(byte_value inside {8'h20, 8'h09, 8'h0D, 8'h0A}))
                    m[xes_pkg::CAND_DECL] = 1'b0;
            end
            default:
            begin
                m = base_mask;
            end
        endcase
    end

    // Count and third-byte flag
    always_comb
    begin
        count_new = (pos < xes_pkg::COUNT_MAX) ? pos + 3'd1 : pos;
        tz_new    = (pos == 3'd2) ? (byte_value == 8'h00) : base_tz;
    end

    // Verdict for a lone candidate once its minimum length is reached
    always_comb
    begin
        one_v = xes_pkg::VERDICT_UNDECIDED;
        case (m)
            11'b1 << xes_pkg::CAND_U8SIG:
                if (count_new >= 3'd3) one_v = xes_pkg::VERDICT_UTF8SIG;
            11'b1 << xes_pkg::CAND_16ASLE,
            11'b1 << xes_pkg::CAND_16ASBE:
                if (count_new >= 3'd2) one_v = xes_pkg::VERDICT_UTF16BOM;
            11'b1 << xes_pkg::CAND_16LE:
                if (count_new >= 3'd4) one_v = xes_pkg::VERDICT_UTF16LE;
            11'b1 << xes_pkg::CAND_16BE:
                if (count_new >= 3'd2) one_v = xes_pkg::VERDICT_UTF16BE;
            11'b1 << xes_pkg::CAND_32ASLE,
            11'b1 << xes_pkg::CAND_32ASBE:
                if (count_new >= 3'd4) one_v = xes_pkg::VERDICT_UTF32BOM;
            11'b1 << xes_pkg::CAND_32LE:
                if (count_new >= 3'd4) one_v = xes_pkg::VERDICT_UTF32LE;
            11'b1 << xes_pkg::CAND_32BE:
                if (count_new >= 3'd4) one_v = xes_pkg::VERDICT_UTF32BE;
            11'b1 << xes_pkg::CAND_CP037:
                if (count_new >= 3'd4) one_v = xes_pkg::VERDICT_CP037;
            11'b1 << xes_pkg::CAND_DECL:
                if (count_new >= 3'd6) one_v = xes_pkg::VERDICT_DECL;
            default:
                one_v = xes_pkg::VERDICT_UNDECIDED;
        endcase
    end

    // Final verdict: an empty mask, or a last byte still undecided, falls back to UTF-8
    always_comb
    begin
        single = (m & (m - 11'd1)) == '0;
        if (m == '0)
            v = xes_pkg::VERDICT_UTF8;
        else if (single)
            v = one_v;
        else
            v = xes_pkg::VERDICT_UNDECIDED;
        if (v == xes_pkg::VERDICT_UNDECIDED && end_of_document)
            v = xes_pkg::VERDICT_UTF8;
    end

    assign nxt.mask       = m;
    assign nxt.count      = count_new;
    assign nxt.third_zero = tz_new;
    assign verdict         = v;
    assign candidates_left = m;

endmodule

[design/xml_encoding_sniffer_unit.sv]
// Top level: input register, sniff logic, state and result register.
// An accepted byte word passes through the input register, then the result register.
// Throughput: one byte word per cycle when the output is not stalled; the state
// update is a single pass of byte compares and a mask update between the input
// and result registers. Reset: candidate mask all ones, byte count and third-byte
// flag zero, both pipeline stages empty.
module xml_encoding_sniffer_unit (
    input  logic        clk,
    input  logic        rst_n,
    xes_in_if.sink      in_ch,
    xes_out_if.source   out_ch
);

    logic                       s1_valid_reg;
    logic [7:0]                 s1_byte_reg;
    logic                       s1_first_reg;
    logic                       s1_last_reg;
    xes_pkg::sniff_state_t      state_reg;
    xes_pkg::sniff_state_t      state_next;
    logic                       out_valid_reg;
    logic [3:0]                 out_verdict_reg;
    logic [xes_pkg::CAND_W-1:0] out_cand_reg;
    logic [3:0]                 core_verdict;
    logic [xes_pkg::CAND_W-1:0] core_cand;
    logic                       advance;
    logic                       in_take;

    // Pipeline flow control
    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    xes_sniff_core u_core (
        .cur               (state_reg),
        .byte_value        (s1_byte_reg),
        .first_of_document (s1_first_reg),
        .end_of_document   (s1_last_reg),
        .nxt               (state_next),
        .verdict           (core_verdict),
        .candidates_left   (core_cand)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg  <= in_ch.byte_value;
            s1_first_reg <= in_ch.first_of_document;
            s1_last_reg  <= in_ch.end_of_document;
        end
    end

    // Detection state and valid of the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mask       <= xes_pkg::CAND_ALL;
            state_reg.count      <= 3'd0;
            state_reg.third_zero <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
                state_reg <= state_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_verdict_reg <= core_verdict;
            out_cand_reg    <= core_cand;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.verdict         = out_verdict_reg;
    assign out_ch.candidates_left = out_cand_reg;

endmodule

[tb/sv/xes_verdict_check.sv]
// Checker for the XML encoding sniffer: predicts verdict and candidate mask per word and compares.
module xes_verdict_check (
    input  logic clk,
    input  logic rst_n,
    xes_in_if    in_ch,
    xes_out_if   out_ch,
    output int   mismatches,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]                 verdict;
        logic [xes_pkg::CAND_W-1:0] mask;
    } sniff_result_t;

    // Expected results in acceptance order
    sniff_result_t         verdict_q[$];
    // Predicted detection state
    xes_pkg::sniff_state_t doc_state;
    int                    fail_count;

    // Mask of candidates that survive byte b at position pos
    function automatic logic [xes_pkg::CAND_W-1:0] narrow_candidates(
        input logic [xes_pkg::CAND_W-1:0] m,
        input logic [2:0]                 pos,
        input logic [7:0]                 b,
        input logic                       third_zero);
        logic [xes_pkg::CAND_W-1:0] keep;
        keep = xes_pkg::CAND_ALL;
        case (pos)
            3'd0:
            begin
                keep[xes_pkg::CAND_U8SIG]  = (b == 8'hEF);
                keep[xes_pkg::CAND_16ASLE] = (b == 8'hFF);
                keep[xes_pkg::CAND_32ASLE] = (b == 8'hFF);
                keep[xes_pkg::CAND_16ASBE] = (b == 8'hFE);
                keep[xes_pkg::CAND_16LE]   = (b == 8'h3C);
                keep[xes_pkg::CAND_32LE]   = (b == 8'h3C);
                keep[xes_pkg::CAND_DECL]   = (b == 8'h3C);
                keep[xes_pkg::CAND_32ASBE] = (b == 8'h00);
                keep[xes_pkg::CAND_32BE]   = (b == 8'h00);
                keep[xes_pkg::CAND_16BE]   = (b == 8'h00);
                keep[xes_pkg::CAND_CP037]  = (b == 8'h4C);
            end
            3'd1:
            begin
                keep[xes_pkg::CAND_U8SIG]  = (b == 8'hBB);
                keep[xes_pkg::CAND_16ASLE] = (b == 8'hFE);
                keep[xes_pkg::CAND_32ASLE] = (b == 8'hFE);
                keep[xes_pkg::CAND_16ASBE] = (b == 8'hFF);
                keep[xes_pkg::CAND_16LE]   = (b == 8'h00);
                keep[xes_pkg::CAND_32ASBE] = (b == 8'h00);
                keep[xes_pkg::CAND_32LE]   = (b == 8'h00);
                keep[xes_pkg::CAND_32BE]   = (b == 8'h00);
                keep[xes_pkg::CAND_16BE]   = (b == 8'h3C);
                keep[xes_pkg::CAND_CP037]  = (b == 8'h6F);
                keep[xes_pkg::CAND_DECL]   = (b == 8'h3F);
            end
            3'd2:
            begin
                keep[xes_pkg::CAND_U8SIG]  = (b == 8'hBF);
                keep[xes_pkg::CAND_16LE]   = (b == 8'h3F);
                keep[xes_pkg::CAND_32ASLE] = (b == 8'h00);
                keep[xes_pkg::CAND_32LE]   = (b == 8'h00);
                keep[xes_pkg::CAND_32BE]   = (b == 8'h00);
                keep[xes_pkg::CAND_32ASBE] = (b == 8'hFE);
                keep[xes_pkg::CAND_CP037]  = (b == 8'hA7);
                keep[xes_pkg::CAND_DECL]   = (b == 8'h78);
            end
            3'd3:
            begin
                // FF FE 00 00 is a UTF-32 mark, not UTF-16
                keep[xes_pkg::CAND_16ASLE] = !(b == 8'h00 && third_zero);
                keep[xes_pkg::CAND_16LE]   = (b == 8'h00);
                keep[xes_pkg::CAND_32ASLE] = (b == 8'h00);
                keep[xes_pkg::CAND_32LE]   = (b == 8'h00);
                keep[xes_pkg::CAND_32ASBE] = (b == 8'hFF);
                keep[xes_pkg::CAND_32BE]   = (b == 8'h3C);
                keep[xes_pkg::CAND_CP037]  = (b == 8'h94);
                keep[xes_pkg::CAND_DECL]   = (b == 8'h6D);
            end
            3'd4:
            begin
                keep[xes_pkg::CAND_DECL] = (b == 8'h6C);
            end
            3'd5:
            begin
                // declaration name must be followed by white space
                keep[xes_pkg::CAND_DECL] = (b == 8'h20 || b == 8'h09 ||
                                            b == 8'h0D || b == 8'h0A);
            end
            default:
            begin
                keep = xes_pkg::CAND_ALL;
            end
        endcase
        return m & keep;
    endfunction

    // Verdict from the mask after n bytes
    function automatic logic [3:0] settle_verdict(input logic [xes_pkg::CAND_W-1:0] m,
                                                  input logic [2:0] n,
                                                  input logic last);
        logic [3:0] v;
        v = xes_pkg::VERDICT_UNDECIDED;
        if (m == '0)
            v = xes_pkg::VERDICT_UTF8;
        else if ($onehot(m))
        begin
            if (m[xes_pkg::CAND_U8SIG] && n >= 3'd3)
                v = xes_pkg::VERDICT_UTF8SIG;
            else if ((m[xes_pkg::CAND_16ASLE] || m[xes_pkg::CAND_16ASBE]) && n >= 3'd2)
                v = xes_pkg::VERDICT_UTF16BOM;
            else if (m[xes_pkg::CAND_16LE] && n >= 3'd4)
                v = xes_pkg::VERDICT_UTF16LE;
            else if (m[xes_pkg::CAND_16BE] && n >= 3'd2)
                v = xes_pkg::VERDICT_UTF16BE;
            else if ((m[xes_pkg::CAND_32ASLE] || m[xes_pkg::CAND_32ASBE]) && n >= 3'd4)
                v = xes_pkg::VERDICT_UTF32BOM;
            else if (m[xes_pkg::CAND_32LE] && n >= 3'd4)
                v = xes_pkg::VERDICT_UTF32LE;
            else if (m[xes_pkg::CAND_32BE] && n >= 3'd4)
                v = xes_pkg::VERDICT_UTF32BE;
            else if (m[xes_pkg::CAND_CP037] && n >= 3'd4)
                v = xes_pkg::VERDICT_CP037;
            else if (m[xes_pkg::CAND_DECL] && n >= xes_pkg::COUNT_MAX)
                v = xes_pkg::VERDICT_DECL;
        end
        if (v == xes_pkg::VERDICT_UNDECIDED && last)
            v = xes_pkg::VERDICT_UTF8;
        return v;
    endfunction

    // Advance the predicted state by one byte word and return its result
    function automatic sniff_result_t predict_verdict(input logic [7:0] b,
                                                      input logic first,
                                                      input logic last);
        sniff_result_t r;
        if (first)
        begin
            doc_state.mask       = xes_pkg::CAND_ALL;
            doc_state.count      = 3'd0;
            doc_state.third_zero = 1'b0;
        end
        if (doc_state.count < xes_pkg::COUNT_MAX)
        begin
            doc_state.mask = narrow_candidates(doc_state.mask, doc_state.count, b,
                                               doc_state.third_zero);
            if (doc_state.count == 3'd2)
                doc_state.third_zero = (b == 8'h00);
            doc_state.count = doc_state.count + 3'd1;
        end
        r.mask    = doc_state.mask;
        r.verdict = settle_verdict(doc_state.mask, doc_state.count, last);
        return r;
    endfunction

    task automatic note_failure(input string what, input sniff_result_t want,
                                input sniff_result_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t verdict check failed (%s): verdict exp %0d got %0d, mask exp %h got %h",
                     $realtime, what, want.verdict, got.verdict, want.mask, got.mask);
    endtask

    // Compare accepted results, then queue the prediction for an accepted byte
    always @(posedge clk or negedge rst_n)
    begin : watch
        sniff_result_t want;
        sniff_result_t got;
        if (!rst_n)
        begin
            doc_state.mask       = xes_pkg::CAND_ALL;
            doc_state.count      = 3'd0;
            doc_state.third_zero = 1'b0;
            verdict_q.delete();
            fail_count = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.verdict = out_ch.verdict;
                got.mask    = out_ch.candidates_left;
                if (verdict_q.size() == 0)
                begin
                    want = '0;
                    note_failure("unexpected word", want, got);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (got.verdict !== want.verdict || got.mask !== want.mask)
                        note_failure("wrong field", want, got);
                end
            end
            if (in_ch.valid && in_ch.ready)
                verdict_q.push_back(predict_verdict(in_ch.byte_value, in_ch.first_of_document,
                                                    in_ch.end_of_document));
            mismatches <= fail_count;
            pending    <= verdict_q.size();
        end
    end

endmodule

[tb/sv/xml_encoding_sniffer_unit_test.sv]
// Testbench top for the XML encoding sniffer: clock, reset, byte stimulus and verdict.
module xml_encoding_sniffer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1900;
    localparam int LIMIT       = 100000;
    localparam int DRAIN       = 8;

    // Bytes that matter to some candidate
    localparam logic [7:0] MARK_BYTES [19] = '{
        8'h00, 8'hFF, 8'hFE, 8'hEF, 8'hBB, 8'hBF, 8'h3C, 8'h3F, 8'h78, 8'h6D,
        8'h6C, 8'h4C, 8'h6F, 8'hA7, 8'h94, 8'h20, 8'h09, 8'h0D, 8'h0A};
    localparam logic [7:0] SPACE_BYTES [4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};

    logic clk = 1'b0;
    logic rst_n;
    logic steady_stretch;
    int   mismatches;
    int   pending;
    int   words_sent;
    int   cycle_count;

    xes_in_if  in_ch ();
    xes_out_if out_ch ();

    xml_encoding_sniffer_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    xes_verdict_check verdict_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #6 clk = ~clk;

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 1) == 0)
            return MARK_BYTES[$urandom_range(0, 18)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one byte word, with random idle cycles ahead of it
    task automatic send_word(input logic [7:0] b, input logic first, input logic last);
        while (!steady_stretch && $urandom_range(0, 99) < 19)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.byte_value        <= b;
        in_ch.first_of_document <= first;
        in_ch.end_of_document   <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // One document head: mostly a known signature with random damage and tail
    task automatic send_document();
        logic [7:0] doc[$];
        logic       restart;
        logic       closing;
        logic       first;
        logic       last;
        case ($urandom_range(0, 13))
            0:       doc = '{8'hEF, 8'hBB, 8'hBF};
            1:       doc = '{8'hFF, 8'hFE, pick_byte(), pick_byte()};
            2:       doc = '{8'hFE, 8'hFF};
            3:       doc = '{8'h3C, 8'h00, 8'h3F, 8'h00};
            4:       doc = '{8'h00, 8'h3C};
            5:       doc = '{8'hFF, 8'hFE, 8'h00, 8'h00};
            6:       doc = '{8'h00, 8'h00, 8'hFE, 8'hFF};
            7:       doc = '{8'h3C, 8'h00, 8'h00, 8'h00};
            8:       doc = '{8'h00, 8'h00, 8'h00, 8'h3C};
            9:       doc = '{8'h4C, 8'h6F, 8'hA7, 8'h94};
            10:      doc = '{8'h3C, 8'h3F, 8'h78, 8'h6D, 8'h6C,
                             SPACE_BYTES[$urandom_range(0, 3)]};
            11:      doc = '{8'hFF, 8'hFE, 8'h00, 8'($urandom_range(1, 255))};
            default:
            begin
                repeat ($urandom_range(1, 8))
                    doc.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        // damage one byte now and then
        if ($urandom_range(0, 3) == 0)
            doc[$urandom_range(0, doc.size() - 1)] = pick_byte();
        repeat ($urandom_range(0, 4))
            doc.push_back(pick_byte());
        restart = ($urandom_range(0, 9) != 0);
        closing = ($urandom_range(0, 1) == 0);
        foreach (doc[i])
        begin
            first = (i == 0) ? restart : ($urandom_range(0, 39) == 0);
            last  = (i == doc.size() - 1) ? closing : ($urandom_range(0, 19) == 0);
            send_word(doc[i], first, last);
        end
    endtask

    // Receiver: random stalls except during the steady stretch
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= steady_stretch || ($urandom_range(0, 99) >= 19);
        end
    end

    // Watchdog
    initial
    begin
        for (cycle_count = 0; cycle_count < LIMIT; cycle_count++)
            @(posedge clk);
        $display("xml_encoding_sniffer_unit: mismatch");
        $finish;
    end

    initial
    begin
        logic held;
        held                    = 1'b0;
        words_sent              = 0;
        steady_stretch          = 1'b0;
        rst_n                   = 1'b0;
        in_ch.valid             = 1'b0;
        in_ch.byte_value        = 8'h00;
        in_ch.first_of_document = 1'b0;
        in_ch.end_of_document   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Declaration right after reset, with no restart flag; tab as separator
        send_word(8'h3C, 1'b0, 1'b0);
        send_word(8'h3F, 1'b0, 1'b0);
        send_word(8'h78, 1'b0, 1'b0);
        send_word(8'h6D, 1'b0, 1'b0);
        send_word(8'h6C, 1'b0, 1'b0);
        send_word(8'h09, 1'b0, 1'b0);
        // byte past the sixth, carrying the end flag
        send_word(8'h41, 1'b0, 1'b1);
        // UTF-32 little-endian mark
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'hFE, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        // restart and end on the same byte
        send_word(8'h00, 1'b1, 1'b1);
        // UTF-8 mark, ended
        send_word(8'hEF, 1'b1, 1'b0);
        send_word(8'hBB, 1'b0, 1'b0);
        send_word(8'hBF, 1'b0, 1'b1);
        // UTF-16 big-endian mark
        send_word(8'hFE, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        // cp037 "<?xm"
        send_word(8'h4C, 1'b1, 1'b0);
        send_word(8'h6F, 1'b0, 1'b0);
        send_word(8'hA7, 1'b0, 1'b0);
        send_word(8'h94, 1'b0, 1'b0);

        // Random documents
        while (words_sent < ITEM_TARGET)
        begin
            steady_stretch <= (words_sent >= 700 && words_sent < 1000);
            // hold off once until the block has drained
            if (!held && words_sent >= 1200)
            begin
                held = 1'b1;
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            send_document();
        end
        in_ch.valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("xml_encoding_sniffer_unit: match");
        else
            $display("xml_encoding_sniffer_unit: mismatch");
        $finish;
    end

endmodule

[xml_encoding_sniffer_unit.f]
design/xes_pkg.sv
design/xes_in_if.sv
design/xes_out_if.sv
design/xes_sniff_core.sv
design/xml_encoding_sniffer_unit.sv
tb/sv/xes_verdict_check.sv
tb/sv/xml_encoding_sniffer_unit_test.sv
